/* rtl/bsa_pkg.sv */
`default_nettype none

package bsa_pkg;

    // Block dimensions.
    localparam int CUSTOMERS  = 5;
    localparam int RESOURCES  = 4;
    localparam int COUNT_BITS = 8;

    // Configuration register file: one maximum-claim word per customer slot,
    // then the total-units word.
    localparam int MAX_REGS      = 5;
    localparam int MAX_IDX_BITS  = 3;
    localparam int CFG_IDX_BITS  = 3;

    // Customer index, finished counter and wide accumulator widths.
    localparam int CIDX_BITS = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int CNT_BITS  = $clog2(CUSTOMERS + 1);
    localparam int SUM_RAW   = COUNT_BITS + $clog2(CUSTOMERS + 1);
    localparam int SUM_BITS  = (SUM_RAW > 8) ? SUM_RAW : 9;

    typedef logic [COUNT_BITS-1:0]                 t_count;
    typedef logic [SUM_BITS-1:0]                   t_wide;
    typedef logic [RESOURCES-1:0][COUNT_BITS-1:0]  t_row;
    typedef logic [RESOURCES-1:0][SUM_BITS-1:0]    t_work;
    typedef logic [RESOURCES-1:0][7:0]             t_amts;

    typedef enum logic [2:0] {
        ST_GRANTED      = 3'd0,
        ST_RELEASED     = 3'd1,
        ST_BAD_CUSTOMER = 3'd2,
        ST_OVER_NEED    = 3'd3,
        ST_OVER_AVAIL   = 3'd4,
        ST_UNSAFE       = 3'd5,
        ST_OVER_ALLOC   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SAFE,
        S_COMMIT,
        S_DONE
    } t_state;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAX_0 = 3'd0,
        CFG_MAX_1 = 3'd1,
        CFG_MAX_2 = 3'd2,
        CFG_MAX_3 = 3'd3,
        CFG_MAX_4 = 3'd4,
        CFG_TOTAL = 3'd5
    } t_cfg_index;

    // Result of evaluating one allocation row against the current item.
    typedef struct packed {
        logic fits;
        logic over_need;
        logic over_alloc;
    } t_row_flags;

    // One 8-bit lane of a packed configuration word, cut to the count width.
    function automatic t_count lane(input logic [31:0] word, input int r);
        logic [15:0] b;
        b = {8'd0, word[8*r +: 8]};
        return b[COUNT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/bsa_row_unit.sv */
`default_nettype none

// Evaluates one allocation row per cycle: need, bound checks against the
// item amounts, the fit test against the work vector and the next work vector.
module bsa_row_unit import bsa_pkg::*; (
    input  wire t_row       i_row,
    input  wire [31:0]      i_max,
    input  wire t_amts      i_amt,
    input  wire             i_is_cust,
    input  wire t_work      i_work,
    output t_row_flags      o_flags,
    output t_work           o_work_next
);

    always_comb begin
        t_count m;
        t_count need;
        t_wide  need_w;
        t_wide  alloc_w;
        t_wide  amt_w;
        t_wide  nd;
        o_flags     = '{fits: 1'b1, over_need: 1'b0, over_alloc: 1'b0};
        o_work_next = '0;
        for (int r = 0; r < RESOURCES; r++) begin
            m       = lane(i_max, r);
            need    = (i_row[r] >= m) ? '0 : t_count'(m - i_row[r]);
            need_w  = t_wide'(need);
            alloc_w = t_wide'(i_row[r]);
            amt_w   = t_wide'(i_amt[r]);
            if (amt_w > need_w) begin
                o_flags.over_need = 1'b1;
            end
            if (amt_w > alloc_w) begin
                o_flags.over_alloc = 1'b1;
            end
            // The requesting customer is tested as if the request were granted.
            nd = i_is_cust ? t_wide'(need_w - amt_w) : need_w;
            if (i_work[r] < nd) begin
                o_flags.fits = 1'b0;
            end
            o_work_next[r] = t_wide'(i_work[r] + alloc_w + (i_is_cust ? amt_w : t_wide'(0)));
        end
    end

endmodule

`default_nettype wire

/* rtl/bankers_safety_allocator_top.sv */
`default_nettype none

// Banker's-algorithm resource allocator. Each input transfer is a request
// (tuser 0) or a release (tuser 1) of four resource amounts for one customer,
// and each one yields exactly one result transfer carrying a status code, the
// number of customers the safety check finished and the available units of
// every resource after the step. Maximum claims and the resource totals are
// written through the configuration channel, only while the block is idle: the
// user is bound to this, and the block itself does not enforce it; writes to
// indexes past the total-units register are ignored. The allocation matrix is
// held in flip-flops and cleared by reset, and per-resource column sums are
// kept alongside it so that available units are always at hand. An item goes
// through the need, available and allocation checks, then for requests that
// pass them a safety scan that tests one allocation row per cycle in a single
// shared row unit, restarting from customer 0 after every finished customer,
// then a commit step for a grant and the load of the output register once it
// is free. A new item can be accepted in the cycle after its predecessor's
// result is loaded. The input side is ready only while no item is in work; a
// finished result may wait in the output register while the next item is
// accepted and processed, and a result that finds the output register still
// full waits until it drains.
module bankers_safety_allocator_top import bsa_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write channel.
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [2:0]   i_cfg_index,
    input  wire [31:0]  i_cfg_data,
    // Item input.
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [39:0]  i_s_axis_tdata,   // customer[2:0], amount_0..amount_3, zero pad
    input  wire         i_s_axis_tuser,   // action
    // Result output.
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // finished_count[2:0], avail_0..avail_3, zero pad
    output logic [2:0]  o_m_axis_tuser    // status
);

    // Configuration registers.
    logic [31:0] r_max [MAX_REGS];
    logic [31:0] r_total;

    // Allocation matrix and its column sums.
    t_row  r_alloc [CUSTOMERS];
    t_row  n_alloc [CUSTOMERS];
    t_work r_sum, n_sum;

    // Sequencer.
    t_state                 r_state, n_state;
    logic [CIDX_BITS-1:0]   r_idx, n_idx;
    logic [CIDX_BITS-1:0]   r_cust, n_cust;
    logic                   r_cust_ok, n_cust_ok;
    logic                   r_action, n_action;
    logic [CUSTOMERS-1:0]   r_done, n_done;
    logic [CNT_BITS-1:0]    r_count, n_count;
    t_status                r_status, n_status;
    logic                   r_out_valid, n_out_valid;

    // Payload.
    t_amts       r_amt, n_amt;
    t_work       r_work, n_work;
    t_status     r_out_status, n_out_status;
    logic [2:0]  r_out_fin, n_out_fin;
    logic [3:0][7:0] r_out_avail, n_out_avail;

    // Shared row unit connections.
    t_row       row_rd;
    logic [31:0] max_rd;
    t_row_flags flags;
    t_work      work_next;
    t_work      avail;
    logic       in_xfer;
    logic       load_out;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_REGS; c++) begin
                r_max[c] <= '0;
            end
            r_total <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MAX_0: r_max[0] <= i_cfg_data;
                CFG_MAX_1: r_max[1] <= i_cfg_data;
                CFG_MAX_2: r_max[2] <= i_cfg_data;
                CFG_MAX_3: r_max[3] <= i_cfg_data;
                CFG_MAX_4: r_max[4] <= i_cfg_data;
                CFG_TOTAL: r_total  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Available units: total minus the column sum, saturating at zero.
    always_comb begin
        t_wide t;
        for (int r = 0; r < RESOURCES; r++) begin
            t        = t_wide'(lane(r_total, r));
            avail[r] = (r_sum[r] >= t) ? '0 : t_wide'(t - r_sum[r]);
        end
    end

    // The single row read port, addressed by the sequencer index.
    assign row_rd = (int'(r_idx) < CUSTOMERS) ? r_alloc[r_idx] : '0;
    assign max_rd = (int'(r_idx) < MAX_REGS) ? r_max[MAX_IDX_BITS'(r_idx)] : '0;

    bsa_row_unit u_row (
        .i_row       (row_rd),
        .i_max       (max_rd),
        .i_amt       (r_amt),
        .i_is_cust   (r_idx == r_cust),
        .i_work      (r_work),
        .o_flags     (flags),
        .o_work_next (work_next)
    );

    // Sequencer: next state and datapath updates.
    always_comb begin
        logic over_avail;
        n_state      = r_state;
        n_idx        = r_idx;
        n_cust       = r_cust;
        n_cust_ok    = r_cust_ok;
        n_action     = r_action;
        n_done       = r_done;
        n_count      = r_count;
        n_status     = r_status;
        n_alloc      = r_alloc;
        n_sum        = r_sum;
        n_amt        = r_amt;
        n_work       = r_work;
        n_out_status = r_out_status;
        n_out_fin    = r_out_fin;
        n_out_avail  = r_out_avail;
        load_out     = 1'b0;
        over_avail   = 1'b0;
        for (int r = 0; r < RESOURCES; r++) begin
            if (t_wide'(r_amt[r]) > avail[r]) begin
                over_avail = 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cust_ok = (i_s_axis_tdata[2:0] < CUSTOMERS);
                    n_cust    = CIDX_BITS'(i_s_axis_tdata[2:0]);
                    n_idx     = CIDX_BITS'(i_s_axis_tdata[2:0]);
                    n_action  = i_s_axis_tuser;
                    for (int r = 0; r < RESOURCES; r++) begin
                        n_amt[r] = i_s_axis_tdata[3 + 8*r +: 8];
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_count = '0;
                n_state = S_DONE;
                if (!r_cust_ok) begin
                    n_status = ST_BAD_CUSTOMER;
                end else if (r_action) begin
                    if (flags.over_alloc) begin
                        n_status = ST_OVER_ALLOC;
                    end else begin
                        n_status = ST_RELEASED;
                        for (int r = 0; r < RESOURCES; r++) begin
                            n_alloc[r_idx][r] = t_count'(row_rd[r] - t_count'(r_amt[r]));
                            n_sum[r]          = t_wide'(r_sum[r] - t_wide'(r_amt[r]));
                        end
                    end
                end else if (flags.over_need) begin
                    n_status = ST_OVER_NEED;
                end else if (over_avail) begin
                    n_status = ST_OVER_AVAIL;
                end else begin
                    // Work vector starts at available minus the tentative grant.
                    for (int r = 0; r < RESOURCES; r++) begin
                        n_work[r] = t_wide'(avail[r] - t_wide'(r_amt[r]));
                    end
                    n_done  = '0;
                    n_idx   = '0;
                    n_state = S_SAFE;
                end
            end
            S_SAFE: begin
                if (!r_done[r_idx] && flags.fits) begin
                    n_work         = work_next;
                    n_done[r_idx]  = 1'b1;
                    n_count        = r_count + CNT_BITS'(1);
                    if (int'(r_count) + 1 == CUSTOMERS) begin
                        n_status = ST_GRANTED;
                        n_idx    = r_cust;
                        n_state  = S_COMMIT;
                    end else begin
                        n_idx = '0;
                    end
                end else if (int'(r_idx) == CUSTOMERS - 1) begin
                    // A whole pass found nobody who can finish.
                    n_status = ST_UNSAFE;
                    n_state  = S_DONE;
                end else begin
                    n_idx = r_idx + CIDX_BITS'(1);
                end
            end
            S_COMMIT: begin
                for (int r = 0; r < RESOURCES; r++) begin
                    n_alloc[r_idx][r] = t_count'(row_rd[r] + t_count'(r_amt[r]));
                    n_sum[r]          = t_wide'(r_sum[r] + t_wide'(r_amt[r]));
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    load_out     = 1'b1;
                    n_out_status = r_status;
                    n_out_fin    = 3'(r_count);
                    for (int r = 0; r < 4; r++) begin
                        n_out_avail[r] = (r < RESOURCES) ? 8'(avail[r]) : 8'd0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state and the allocation matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cust      <= '0;
            r_cust_ok   <= 1'b0;
            r_action    <= 1'b0;
            r_done      <= '0;
            r_count     <= '0;
            r_status    <= ST_GRANTED;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            for (int c = 0; c < CUSTOMERS; c++) begin
                r_alloc[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cust      <= n_cust;
            r_cust_ok   <= n_cust_ok;
            r_action    <= n_action;
            r_done      <= n_done;
            r_count     <= n_count;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
            r_alloc     <= n_alloc;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_amt        <= n_amt;
        r_work       <= n_work;
        r_out_status <= n_out_status;
        r_out_fin    <= n_out_fin;
        r_out_avail  <= n_out_avail;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {5'd0, r_out_avail[3], r_out_avail[2], r_out_avail[1],
                              r_out_avail[0], r_out_fin};

    // The finished counter tracks the set of finished customers during the scan.
    a_count_matches_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SAFE |-> $countones(r_done) == int'(r_count))
        else $error("finished count differs from finished set");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SAFE |-> int'(r_idx) < CUSTOMERS)
        else $error("safety scan index out of range");

    a_grant_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_GRANTED |-> int'(r_out_fin) == (CUSTOMERS % 8))
        else $error("grant reported without all customers finished");

    a_unsafe_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_UNSAFE |-> int'(r_out_fin) < CUSTOMERS)
        else $error("unsafe reported with all customers finished");

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state == S_CHECK)
        else $error("accepted item did not enter the check step");

endmodule

`default_nettype wire

/* dv/tb_bankers_safety_allocator_top.sv */
`timescale 1ns / 100ps

module tb_bankers_safety_allocator_top;
    import bsa_pkg::*;

    localparam int          CLK_PERIOD   = 4;
    localparam int          RESET_CYCLES = 3;
    localparam int          PHASES       = 9;
    localparam int          PHASE_ITEMS  = 80;
    localparam int          DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 500_000;
    localparam int          LOUD_LIMIT   = 10;

    // Action codes carried on the input tuser line.
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Register indexes past the total-units word; writes there must change nothing.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // What one item should produce: the status code, the number of customers
    // the safety scan finished and the four available counts, resource 0 lowest.
    typedef struct packed {
        t_status     status;
        logic [2:0]  finished;
        logic [31:0] avail;
    } t_outcome;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One line of the directed plan. For items, sel is the customer and word holds
    // the four amounts; for register writes, sel is the index and word the data.
    typedef struct packed {
        t_row_kind   kind;
        logic        act;
        logic [2:0]  sel;
        logic [31:0] word;
        logic        typed;
        t_outcome    want;
    } t_plan_row;

    // Mixes of register settings used by the random phases.
    typedef enum int {MIX_SMALL, MIX_FULL, MIX_ONES, MIX_ZERO} t_mix;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [2:0]  i_cfg_index     = '0;
    logic [31:0] i_cfg_data      = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [39:0] i_s_axis_tdata  = '0;   // customer[2:0], amount_0..amount_3, zero pad
    logic        i_s_axis_tuser  = 1'b0; // action
    logic        i_m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;         // finished_count[2:0], avail_0..avail_3, zero pad
    logic [2:0]  o_m_axis_tuser;         // status

    bankers_safety_allocator_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Allocation ledger. This is the testbench's own copy of the block's
    // state: the units each customer holds, the maximum-claim words and the
    // total-units word. It is advanced once per accepted transfer.
    // ------------------------------------------------------------------
    logic [7:0]  held [CUSTOMERS][RESOURCES];
    logic [31:0] claim_word [MAX_REGS];
    logic [31:0] total_word;

    t_outcome    decisions_due[$];
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;

    // Driver bookkeeping: which valid lines are currently held high and how
    // many transfers remain in the current sender burst.
    logic item_up    = 1'b0;
    logic cfg_up     = 1'b0;
    int   burst_left = 0;

    function automatic int claim_of(int c, int r);
        if (c >= MAX_REGS) return 0;
        return claim_word[c][8*r +: 8];
    endfunction

    // A customer holding more than its claim, after the claim was lowered, needs
    // nothing rather than a negative amount.
    function automatic int need_of(int c, int r);
        int m;
        int a;
        m = claim_of(c, r);
        a = held[c][r];
        return (a >= m) ? 0 : m - a;
    endfunction

    // Free units of one resource; zero when the total was lowered under the sum held.
    function automatic int free_of(int r);
        int sum;
        int t;
        sum = 0;
        t   = total_word[8*r +: 8];
        for (int c = 0; c < CUSTOMERS; c++) sum += held[c][r];
        return (sum >= t) ? 0 : t - sum;
    endfunction

    // Safety scan with the request tentatively granted: repeatedly take the first
    // unfinished customer whose need fits the pool, return its units to the pool,
    // and start over from customer 0. Returns how many customers finished.
    function automatic int safe_finishers(int cust, logic [31:0] amts);
        int   pool [RESOURCES];
        logic done [CUSTOMERS];
        int   count;
        logic progress;
        logic fits;
        int   nd;
        for (int r = 0; r < RESOURCES; r++) pool[r] = free_of(r) - int'(amts[8*r +: 8]);
        for (int c = 0; c < CUSTOMERS; c++) done[c] = 1'b0;
        count    = 0;
        progress = 1'b1;
        while (progress && count < CUSTOMERS) begin
            progress = 1'b0;
            for (int c = 0; c < CUSTOMERS && !progress; c++) begin
                if (!done[c]) begin
                    fits = 1'b1;
                    for (int r = 0; r < RESOURCES; r++) begin
                        nd = need_of(c, r);
                        if (c == cust) nd -= int'(amts[8*r +: 8]);
                        if (pool[r] < nd) fits = 1'b0;
                    end
                    if (fits) begin
                        for (int r = 0; r < RESOURCES; r++) begin
                            pool[r] += held[c][r];
                            if (c == cust) pool[r] += int'(amts[8*r +: 8]);
                        end
                        done[c]  = 1'b1;
                        count++;
                        progress = 1'b1;
                    end
                end
            end
        end
        return count;
    endfunction

    // Decides one request or release against the ledger, commits it when it
    // goes through, and returns the outcome the block should report.
    function automatic t_outcome banker_decide(logic act, logic [2:0] cust, logic [31:0] amts);
        t_outcome o;
        int       c;
        int       fin;
        o.status   = ST_GRANTED;
        o.finished = '0;
        c          = int'(cust);
        if (c >= CUSTOMERS) begin
            o.status = ST_BAD_CUSTOMER;
        end else if (act == ACT_RELEASE) begin
            o.status = ST_RELEASED;
            for (int r = 0; r < RESOURCES; r++)
                if (amts[8*r +: 8] > held[c][r]) o.status = ST_OVER_ALLOC;
            if (o.status == ST_RELEASED)
                for (int r = 0; r < RESOURCES; r++) held[c][r] -= amts[8*r +: 8];
        end else begin
            // Need is checked first, then availability, then safety.
            for (int r = 0; r < RESOURCES; r++)
                if (int'(amts[8*r +: 8]) > need_of(c, r)) o.status = ST_OVER_NEED;
            if (o.status == ST_GRANTED)
                for (int r = 0; r < RESOURCES; r++)
                    if (int'(amts[8*r +: 8]) > free_of(r)) o.status = ST_OVER_AVAIL;
            if (o.status == ST_GRANTED) begin
                fin        = safe_finishers(c, amts);
                o.finished = fin[2:0];
                if (fin == CUSTOMERS) begin
                    for (int r = 0; r < RESOURCES; r++) held[c][r] += amts[8*r +: 8];
                end else begin
                    o.status = ST_UNSAFE;
                end
            end
        end
        for (int r = 0; r < RESOURCES; r++) o.avail[8*r +: 8] = 8'(free_of(r));
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks. All input changes are nonblocking and happen at a rising
    // edge, and each valid line gets at most one assignment per edge.
    // ------------------------------------------------------------------

    // Register writes happen only with the block idle: the item valid is dropped
    // and every expected result must have been taken before the write goes out.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        if (item_up) begin
            i_s_axis_tvalid <= 1'b0;
            item_up = 1'b0;
        end
        while (decisions_due.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        cfg_up = 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < MAX_REGS) claim_word[idx] = data;
        else if (idx == CFG_TOTAL) total_word = data;
    endtask

    // Sends one item. The sender works in bursts; at the start of a new burst it
    // may idle for a random gap so that pauses land on every phase of the
    // block's work. The expectation is recorded at the transfer itself.
    task automatic send_item(input logic act, input logic [2:0] cust, input logic [31:0] amts,
                             input logic typed, input t_outcome typed_want);
        int       gap;
        t_outcome got;
        if (cfg_up) begin
            i_cfg_valid <= 1'b0;
            cfg_up = 1'b0;
        end
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
            if (gap > 0) begin
                if (item_up) begin
                    i_s_axis_tvalid <= 1'b0;
                    item_up = 1'b0;
                end
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        item_up = 1'b1;
        i_s_axis_tuser <= act;
        i_s_axis_tdata <= {5'd0, amts, cust};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        got = banker_decide(act, cust, amts);
        decisions_due.push_back(typed ? typed_want : got);
    endtask

    // Random item, mostly well formed: requests that stay within need (and
    // usually within what is free), releases within what is held, then requests
    // or releases just over the limit on one resource, then plain noise.
    task automatic random_item(output logic act, output logic [2:0] cust,
                               output logic [31:0] amts);
        int pick;
        int c;
        int r;
        int lim;
        pick = $urandom_range(0, 99);
        c    = $urandom_range(0, CUSTOMERS - 1);
        cust = 3'(c);
        amts = '0;
        if (pick < 50) begin
            act = ACT_REQUEST;
            for (int k = 0; k < RESOURCES; k++) begin
                lim = need_of(c, k);
                if ($urandom_range(0, 2) != 0 && free_of(k) < lim) lim = free_of(k);
                if ($urandom_range(0, 1) == 1 && lim > 3) lim = 3;
                amts[8*k +: 8] = 8'($urandom_range(0, lim));
            end
        end else if (pick < 75) begin
            act = ACT_RELEASE;
            for (int k = 0; k < RESOURCES; k++)
                amts[8*k +: 8] = 8'($urandom_range(0, held[c][k]));
        end else if (pick < 85) begin
            act = 1'($urandom_range(0, 1));
            r   = $urandom_range(0, RESOURCES - 1);
            lim = (act == ACT_RELEASE) ? int'(held[c][r]) : need_of(c, r);
            amts[8*r +: 8] = 8'((lim < 255) ? lim + 1 : lim);
        end else begin
            act  = 1'($urandom_range(0, 1));
            cust = 3'($urandom_range(0, 7));
            amts = $urandom;
        end
    endtask

    // Writes every register for one random phase. Claims stay within the totals
    // except now and then in the full-range mix, and the allocations left over
    // from the previous phase may well sit above the new limits.
    task automatic configure_phase(input t_mix mix);
        logic [31:0] tot;
        logic [31:0] claim;
        for (int r = 0; r < RESOURCES; r++) begin
            case (mix)
                MIX_SMALL: tot[8*r +: 8] = 8'($urandom_range(0, 15));
                MIX_FULL:  tot[8*r +: 8] = 8'($urandom_range(0, 255));
                MIX_ONES:  tot[8*r +: 8] = 8'hFF;
                default:   tot[8*r +: 8] = 8'h00;
            endcase
        end
        for (int c = 0; c < MAX_REGS; c++) begin
            for (int r = 0; r < RESOURCES; r++) begin
                if (mix == MIX_FULL && $urandom_range(0, 3) == 0)
                    claim[8*r +: 8] = 8'($urandom_range(0, 255));
                else
                    claim[8*r +: 8] = 8'($urandom_range(0, tot[8*r +: 8]));
            end
            cfg_write(3'(c), claim);
        end
        cfg_write(CFG_TOTAL, tot);
        if ($urandom_range(0, 1) == 1)
            cfg_write(($urandom_range(0, 1) == 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    endtask

    function automatic t_plan_row item_row(logic act, logic [2:0] cust, logic [31:0] amts);
        t_plan_row row;
        row       = '0;
        row.kind  = ROW_ITEM;
        row.act   = act;
        row.sel   = cust;
        row.word  = amts;
        return row;
    endfunction

    function automatic t_plan_row typed_row(logic act, logic [2:0] cust, logic [31:0] amts,
                                            t_status st, logic [2:0] fin, logic [31:0] avail);
        t_plan_row row;
        row               = item_row(act, cust, amts);
        row.typed         = 1'b1;
        row.want.status   = st;
        row.want.finished = fin;
        row.want.avail    = avail;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(logic [2:0] idx, logic [31:0] data);
        t_plan_row row;
        row      = '0;
        row.kind = ROW_CFG;
        row.sel  = idx;
        row.word = data;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Receiver. The ready line follows a pattern of its own that steps
    // through four modes in turn: always ready, coin toss, mostly stalled, and a
    // fixed five-of-eight duty cycle.
    // ------------------------------------------------------------------
    logic [31:0] stall_clock = '0;

    always @(posedge i_clk) begin
        stall_clock <= stall_clock + 1;
        case (stall_clock[10:9])
            2'd0:    i_m_axis_tready <= 1'b1;
            2'd1:    i_m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2:    i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_axis_tready <= (stall_clock[2:0] < 3'd5);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker. Every result transfer is compared field by field with
    // the oldest outstanding expectation. The first few mismatches are
    // printed; later ones are only counted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (decisions_due.size() == 0) begin
                mismatches++;
                if (mismatches <= LOUD_LIMIT)
                    $display("result %0d unexpected: status %0d finished %0d avail %h",
                             results_seen, o_m_axis_tuser, o_m_axis_tdata[2:0],
                             o_m_axis_tdata[34:3]);
            end else begin
                want = decisions_due.pop_front();
                if (o_m_axis_tuser !== want.status || o_m_axis_tdata[2:0] !== want.finished ||
                    o_m_axis_tdata[34:3] !== want.avail) begin
                    mismatches++;
                    if (mismatches <= LOUD_LIMIT)
                        $display("result %0d: want st %0d fin %0d av %h, got st %0d fin %0d av %h",
                                 results_seen, want.status, want.finished, want.avail,
                                 o_m_axis_tuser, o_m_axis_tdata[2:0], o_m_axis_tdata[34:3]);
                end
            end
        end
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[bankers_safety_allocator_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, the directed plan, then the random phases,
    // then drain and report.
    // ------------------------------------------------------------------
    initial begin : main_flow
        t_plan_row   plan[$];
        t_mix        mix;
        logic        act;
        logic [2:0]  cust;
        logic [31:0] amts;
        logic        any_held;

        for (int c = 0; c < CUSTOMERS; c++)
            for (int r = 0; r < RESOURCES; r++) held[c][r] = '0;
        for (int c = 0; c < MAX_REGS; c++) claim_word[c] = '0;
        total_word = '0;

        // Right after reset every claim and total is zero, so the outcomes of the
        // first rows can be written down directly.
        plan.push_back(typed_row(ACT_REQUEST, 3'd0, 32'h0000_0000, ST_GRANTED, 3'd5, '0));
        plan.push_back(typed_row(ACT_REQUEST, 3'd7, 32'hFFFF_FFFF, ST_BAD_CUSTOMER, 3'd0, '0));
        plan.push_back(typed_row(ACT_RELEASE, 3'd5, 32'h0000_0000, ST_BAD_CUSTOMER, 3'd0, '0));
        plan.push_back(typed_row(ACT_RELEASE, 3'd0, 32'h0000_0000, ST_RELEASED, 3'd0, '0));
        plan.push_back(typed_row(ACT_REQUEST, 3'd1, 32'h0100_0000, ST_OVER_NEED, 3'd0, '0));
        plan.push_back(typed_row(ACT_RELEASE, 3'd4, 32'h0000_0001, ST_OVER_ALLOC, 3'd0, '0));
        // Full totals and a full claim for customer 0: it can take everything.
        plan.push_back(cfg_row(CFG_TOTAL, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(CFG_MAX_0, 32'hFFFF_FFFF));
        plan.push_back(typed_row(ACT_REQUEST, 3'd0, 32'hFFFF_FFFF, ST_GRANTED, 3'd5, '0));
        plan.push_back(typed_row(ACT_REQUEST, 3'd1, 32'h0000_0000, ST_GRANTED, 3'd5, '0));
        plan.push_back(typed_row(ACT_REQUEST, 3'd1, 32'h0000_0001, ST_OVER_NEED, 3'd0, '0));
        plan.push_back(cfg_row(CFG_MAX_1, 32'hFFFF_FFFF));
        plan.push_back(typed_row(ACT_REQUEST, 3'd1, 32'h0000_0001, ST_OVER_AVAIL, 3'd0, '0));
        // Total lowered below what is held: available pins at zero.
        plan.push_back(cfg_row(CFG_TOTAL, 32'h0000_0000));
        plan.push_back(typed_row(ACT_RELEASE, 3'd0, 32'h0000_0001, ST_RELEASED, 3'd0, '0));
        // Claim lowered below what is held: need pins at zero, and customer 1 can
        // no longer finish, so a zero request comes out unsafe.
        plan.push_back(cfg_row(CFG_MAX_0, 32'h0000_0000));
        plan.push_back(item_row(ACT_REQUEST, 3'd0, 32'h0000_0000));
        plan.push_back(item_row(ACT_RELEASE, 3'd0, 32'hFFFF_FFFF));
        plan.push_back(item_row(ACT_RELEASE, 3'd0, 32'hFFFF_FFFE));
        // Writes past the register file must leave everything as it is.
        plan.push_back(cfg_row(CFG_SPARE_LO, 32'hDEAD_BEEF));
        plan.push_back(cfg_row(CFG_SPARE_HI, 32'h1234_5678));
        // A textbook allocation scenario, checked against the ledger.
        plan.push_back(cfg_row(CFG_TOTAL, 32'h0807_050A));
        plan.push_back(cfg_row(CFG_MAX_0, 32'h0203_0507));
        plan.push_back(cfg_row(CFG_MAX_1, 32'h0102_0203));
        plan.push_back(cfg_row(CFG_MAX_2, 32'h0302_0009));
        plan.push_back(cfg_row(CFG_MAX_3, 32'h0202_0202));
        plan.push_back(cfg_row(CFG_MAX_4, 32'h0103_0304));
        plan.push_back(item_row(ACT_REQUEST, 3'd0, 32'h0000_0100));
        plan.push_back(item_row(ACT_REQUEST, 3'd1, 32'h0000_0002));
        plan.push_back(item_row(ACT_REQUEST, 3'd2, 32'h0002_0003));
        plan.push_back(item_row(ACT_REQUEST, 3'd3, 32'h0001_0102));
        plan.push_back(item_row(ACT_REQUEST, 3'd4, 32'h0002_0000));
        plan.push_back(item_row(ACT_REQUEST, 3'd4, 32'h0101_0104));
        plan.push_back(item_row(ACT_REQUEST, 3'd0, 32'h0202_0407));
        plan.push_back(item_row(ACT_RELEASE, 3'd1, 32'h0000_0002));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                cfg_write(plan[i].sel, plan[i].word);
            else
                send_item(plan[i].act, plan[i].sel, plan[i].word, plan[i].typed, plan[i].want);
        end

        // Random phases. The ones and zero mixes give the extreme settings; the
        // rest alternate small counts, where grants and unsafe states are
        // common, with the full range.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1, 7:    mix = MIX_FULL;
                3:       mix = MIX_ONES;
                5:       mix = MIX_ZERO;
                default: mix = MIX_SMALL;
            endcase
            configure_phase(mix);
            // About half the phases, chosen at random, open by handing back everything each customer holds.
            if ($urandom_range(0, 1) == 1) begin
                for (int c = 0; c < CUSTOMERS; c++) begin
                    any_held = 1'b0;
                    for (int r = 0; r < RESOURCES; r++) begin
                        amts[8*r +: 8] = held[c][r];
                        if (held[c][r] != 0) any_held = 1'b1;
                    end
                    if (any_held) send_item(ACT_RELEASE, 3'(c), amts, 1'b0, '0);
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item(act, cust, amts);
                send_item(act, cust, amts, 1'b0, '0);
            end
        end

        if (item_up) begin
            i_s_axis_tvalid <= 1'b0;
            item_up = 1'b0;
        end
        if (cfg_up) begin
            i_cfg_valid <= 1'b0;
            cfg_up = 1'b0;
        end
        while (decisions_due.size() != 0) @(posedge i_clk);
        // Let the drain period pass so that a stray extra result is caught.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && decisions_due.size() == 0) begin
            $display("[bankers_safety_allocator_top] OK");
        end else begin
            $display("[bankers_safety_allocator_top] ERROR");
        end
        $finish;
    end

endmodule
